[hdl/plu_pkg.sv]
// ----------------------------------------------------------------------------
// plu_pkg
// Shared constants, types and helper functions of the pivoted LU solver.
// ----------------------------------------------------------------------------
`default_nettype none

package plu_pkg;

	localparam int MAX_ORDER  = 16;
	localparam int DATA_WIDTH = 32;
	localparam int FRAC_BITS  = 16;
	localparam int IDX_W      = $clog2(MAX_ORDER);
	localparam int ORD_W      = IDX_W + 1;
	localparam int ADDR_W     = 2 * IDX_W;
	localparam int CNT_W      = ADDR_W + 1;
	localparam int NSQ_W      = 2 * ORD_W;
	localparam int PROD_W     = 2 * DATA_WIDTH;
	localparam int MQ_W       = PROD_W - FRAC_BITS + 1;
	localparam int UPD_W      = MQ_W + 1;
	localparam int ACC_W      = MQ_W + IDX_W + 3;
	localparam int SIZE_W     = 5;

	localparam logic [SIZE_W-1:0] SIZE_RESET = SIZE_W'(MAX_ORDER);
	localparam logic [2:0]        REG_SIZE_ADDR = 3'd0;

	typedef enum logic [4:0] {
		ST_IDLE,
		ST_LDIV,
		ST_F_INIT,
		ST_F_COL,
		ST_F_BI,
		ST_F_SRCH,
		ST_F_SCMP,
		ST_F_SWAP,
		ST_F_RP,
		ST_F_PIV,
		ST_F_ROW,
		ST_F_DIV,
		ST_F_DWT,
		ST_E_K,
		ST_E_B,
		ST_E_C,
		ST_E_RND,
		ST_E_WR,
		ST_FWD_I,
		ST_FWD_J,
		ST_FWD_A,
		ST_FWD_M,
		ST_FWD_R,
		ST_FWD_S,
		ST_BK_I,
		ST_BK_A,
		ST_BK_J,
		ST_BK_LA,
		ST_BK_M,
		ST_BK_R,
		ST_BK_S,
		ST_BK_D
	} ctl_state_t;

	// XS_BK_DW, XS_EMIT and XS_OUT live in a second enum, ctl_xstate_t.
	typedef enum logic [1:0] {
		XS_NONE,
		XS_BK_DW,
		XS_EMIT,
		XS_OUT
	} ctl_xstate_t;

	typedef enum logic [4:0] {
		LD_NONE,
		LD_RHS,
		LD_RO_INIT,
		LD_BEST_INIT,
		LD_BEST_CMP,
		LD_SWAP,
		LD_PIV,
		LD_A_RD,
		LD_B,
		LD_C,
		LD_ALPHA,
		LD_ACC_RHS,
		LD_ACC_WV,
		LD_ACC_SUB,
		LD_WV_SAT,
		LD_WV_DIV,
		LD_WV_ZERO,
		LD_OUT
	} dp_ld_t;

	typedef enum logic [1:0] {
		WS_IN,
		WS_UPD,
		WS_ALPHA
	} dp_wsel_t;

	typedef struct packed {
		logic             ram_rd;
		logic             ram_wr;
		logic             phys;
		logic [IDX_W-1:0] pos;
		logic [IDX_W-1:0] col;
		dp_wsel_t         wsel;
		dp_ld_t           ld;
		logic             cap_in;
		logic             mul;
		logic             rnd;
		logic             div_start;
		logic             div_solve;
	} dp_cmd_t;

	typedef struct packed {
		logic rd_zero;
		logic better;
		logic div_busy;
	} dp_stat_t;

	function automatic logic [DATA_WIDTH-1:0] mag(input logic signed [DATA_WIDTH-1:0] v);
		logic [DATA_WIDTH-1:0] r;
		r = v[DATA_WIDTH-1] ? DATA_WIDTH'(-v) : DATA_WIDTH'(v);
		return r;
	endfunction

	function automatic logic signed [DATA_WIDTH-1:0] sat_acc(input logic signed [ACC_W-1:0] v);
		logic signed [DATA_WIDTH-1:0] r;
		if ((&v[ACC_W-1:DATA_WIDTH-1]) || !(|v[ACC_W-1:DATA_WIDTH-1])) begin
			r = v[DATA_WIDTH-1:0];
		end else begin
			r = {v[ACC_W-1], {(DATA_WIDTH-1){~v[ACC_W-1]}}};
		end
		return r;
	endfunction

	function automatic logic signed [DATA_WIDTH-1:0] sat_upd(input logic signed [UPD_W-1:0] v);
		logic signed [DATA_WIDTH-1:0] r;
		if ((&v[UPD_W-1:DATA_WIDTH-1]) || !(|v[UPD_W-1:DATA_WIDTH-1])) begin
			r = v[DATA_WIDTH-1:0];
		end else begin
			r = {v[UPD_W-1], {(DATA_WIDTH-1){~v[UPD_W-1]}}};
		end
		return r;
	endfunction

endpackage

`default_nettype wire

[hdl/plu_ram.sv]
// ----------------------------------------------------------------------------
// plu_ram
// Generic single-port-write, single-port-read RAM with registered read data.
// ----------------------------------------------------------------------------
`default_nettype none

module plu_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 256
) (
	input  wire logic                     clk,
	input  wire logic                     we,
	input  wire logic [$clog2(DEPTH)-1:0] waddr,
	input  wire logic [WIDTH-1:0]         wdata,
	input  wire logic                     re,
	input  wire logic [$clog2(DEPTH)-1:0] raddr,
	output logic      [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem_q[raddr];
		end
	end

endmodule

`default_nettype wire

[hdl/plu_div.sv]
// ----------------------------------------------------------------------------
// plu_div
// Signed Q16.16 divider, rounded to nearest with ties away from zero,
// one quotient bit per cycle, saturated result.
// ----------------------------------------------------------------------------
`default_nettype none

module plu_div (
	input  wire logic                                clk,
	input  wire logic                                arst_n,
	input  wire logic                                start,
	input  wire logic signed [plu_pkg::DATA_WIDTH-1:0] num,
	input  wire logic signed [plu_pkg::DATA_WIDTH-1:0] den,
	output logic                                     busy,
	output logic signed [plu_pkg::DATA_WIDTH-1:0]    quot
);
	import plu_pkg::*;

	localparam int N_W = DATA_WIDTH + FRAC_BITS + 1;
	localparam int D_W = DATA_WIDTH + 1;
	localparam int C_W = $clog2(N_W + 1);

	logic [N_W-1:0] nreg_q;
	logic [N_W-1:0] q_q;
	logic [D_W-1:0] den_q;
	logic [D_W-1:0] rem_q;
	logic           neg_q;
	logic [C_W-1:0] cnt_q;
	logic [D_W:0]   trial;
	logic           fit;
	logic [DATA_WIDTH-1:0] ma;
	logic [DATA_WIDTH-1:0] mb;
	logic           pos_ovf;
	logic           neg_ovf;

	assign ma    = mag(num);
	assign mb    = mag(den);
	assign trial = {rem_q, nreg_q[N_W-1]};
	assign fit   = (trial >= {1'b0, den_q});

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q <= '0;
		end else if (start) begin
			cnt_q <= C_W'(N_W);
		end else if (cnt_q != '0) begin
			cnt_q <= cnt_q - 1'b1;
		end
	end

	// Dividend is 2*(|a| << 16) + |b|, divisor 2*|b|: the floor gives the rounded quotient.
	always_ff @(posedge clk) begin
		if (start) begin
			nreg_q <= {ma, {FRAC_BITS{1'b0}}, 1'b0} + N_W'(mb);
			den_q  <= {mb, 1'b0};
			rem_q  <= '0;
			q_q    <= '0;
			neg_q  <= num[DATA_WIDTH-1] ^ den[DATA_WIDTH-1];
		end else if (cnt_q != '0) begin
			nreg_q <= {nreg_q[N_W-2:0], 1'b0};
			rem_q  <= fit ? D_W'(trial - {1'b0, den_q}) : trial[D_W-1:0];
			q_q    <= {q_q[N_W-2:0], fit};
		end
	end

	assign busy    = (cnt_q != '0);
	assign pos_ovf = |q_q[N_W-1:DATA_WIDTH-1];
	assign neg_ovf = (|q_q[N_W-1:DATA_WIDTH]) || (q_q[DATA_WIDTH-1] && (|q_q[DATA_WIDTH-2:0]));

	always_comb begin
		if (neg_q) begin
			quot = neg_ovf ? {1'b1, {(DATA_WIDTH-1){1'b0}}} : -q_q[DATA_WIDTH-1:0];
		end else begin
			quot = pos_ovf ? {1'b0, {(DATA_WIDTH-1){1'b1}}} : q_q[DATA_WIDTH-1:0];
		end
	end

endmodule

`default_nettype wire

[hdl/plu_dp.sv]
// ----------------------------------------------------------------------------
// plu_dp
// Datapath: matrix RAM, row-order table, vectors, multiply-round pipeline,
// accumulator and divider, all driven by controller requests.
// ----------------------------------------------------------------------------
`default_nettype none

module plu_dp (
	input  wire logic                                  clk,
	input  wire logic                                  arst_n,
	input  wire plu_pkg::dp_cmd_t                      cmd,
	output plu_pkg::dp_stat_t                          stat,
	input  wire logic signed [plu_pkg::DATA_WIDTH-1:0] in_value,
	output logic signed [plu_pkg::DATA_WIDTH-1:0]      out_value,
	output logic                                       singular
);
	import plu_pkg::*;

	logic [IDX_W-1:0]             ro_q  [MAX_ORDER];
	logic signed [DATA_WIDTH-1:0] rhs_q [MAX_ORDER];
	logic signed [DATA_WIDTH-1:0] wv_q  [MAX_ORDER];
	logic signed [DATA_WIDTH-1:0] in_q, piv_q, a_q, b_q, c_q, out_q;
	logic [DATA_WIDTH-1:0]        best_q;
	logic [IDX_W-1:0]             pbest_q;
	logic                         sing_q;
	logic [PROD_W-1:0]            prod_s1;
	logic                         neg_s1;
	logic signed [MQ_W-1:0]       mq_q;
	logic signed [ACC_W-1:0]      acc_q;

	logic [ADDR_W-1:0]            addr;
	logic signed [DATA_WIDTH-1:0] rdata;
	logic signed [DATA_WIDTH-1:0] wdata;
	logic signed [UPD_W-1:0]      diff;
	logic [PROD_W-1:0]            rsum;
	logic [MQ_W-2:0]              rmag;
	logic signed [DATA_WIDTH-1:0] dnum, dden, quot;
	logic                         dbusy;

	assign addr = cmd.phys ? {cmd.pos, cmd.col} : {ro_q[cmd.pos], cmd.col};
	assign diff = {{(UPD_W-DATA_WIDTH){c_q[DATA_WIDTH-1]}}, c_q} - {mq_q[MQ_W-1], mq_q};

	always_comb begin
		unique case (cmd.wsel)
			WS_IN:    wdata = in_q;
			WS_UPD:   wdata = sat_upd(diff);
			WS_ALPHA: wdata = a_q;
			default:  wdata = in_q;
		endcase
	end

	plu_ram #(.WIDTH(DATA_WIDTH), .DEPTH(MAX_ORDER * MAX_ORDER)) u_mat (
		.clk   (clk),
		.we    (cmd.ram_wr),
		.waddr (addr),
		.wdata (wdata),
		.re    (cmd.ram_rd),
		.raddr (addr),
		.rdata (rdata)
	);

	assign dnum = cmd.div_solve ? sat_acc(acc_q) : rdata;
	assign dden = cmd.div_solve ? rdata : piv_q;

	plu_div u_div (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (cmd.div_start),
		.num    (dnum),
		.den    (dden),
		.busy   (dbusy),
		.quot   (quot)
	);

	assign rsum = prod_s1 + PROD_W'(1 << (FRAC_BITS - 1));
	assign rmag = rsum[PROD_W-1:FRAC_BITS];

	assign stat.rd_zero  = (rdata == '0);
	assign stat.better   = (mag(rdata) > best_q);
	assign stat.div_busy = dbusy;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int x = 0; x < MAX_ORDER; x++) begin
				ro_q[x] <= IDX_W'(x);
			end
			sing_q <= 1'b0;
		end else begin
			unique case (cmd.ld)
				LD_RO_INIT: begin
					for (int x = 0; x < MAX_ORDER; x++) begin
						ro_q[x] <= IDX_W'(x);
					end
					sing_q <= 1'b0;
				end
				LD_SWAP: begin
					if (pbest_q != cmd.pos) begin
						ro_q[cmd.pos]  <= ro_q[pbest_q];
						ro_q[pbest_q] <= ro_q[cmd.pos];
					end
				end
				LD_PIV: begin
					if (rdata == '0) begin
						sing_q <= 1'b1;
					end
				end
				default: begin
				end
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.cap_in) begin
			in_q <= in_value;
		end
		if (cmd.mul) begin
			prod_s1 <= mag(a_q) * mag(b_q);
			neg_s1  <= a_q[DATA_WIDTH-1] ^ b_q[DATA_WIDTH-1];
		end
		if (cmd.rnd) begin
			mq_q <= neg_s1 ? -{1'b0, rmag} : {1'b0, rmag};
		end
		unique case (cmd.ld)
			LD_RHS:       rhs_q[cmd.pos] <= in_value;
			LD_BEST_INIT: begin
				best_q  <= mag(rdata);
				pbest_q <= cmd.pos;
			end
			LD_BEST_CMP: begin
				if (mag(rdata) > best_q) begin
					best_q  <= mag(rdata);
					pbest_q <= cmd.pos;
				end
			end
			LD_PIV:       piv_q <= rdata;
			LD_A_RD: begin
				a_q <= rdata;
				b_q <= wv_q[cmd.col];
			end
			LD_B:         b_q <= rdata;
			LD_C:         c_q <= rdata;
			LD_ALPHA:     a_q <= quot;
			LD_ACC_RHS: begin
				acc_q <= {{(ACC_W-DATA_WIDTH){rhs_q[ro_q[cmd.pos]][DATA_WIDTH-1]}},
				          rhs_q[ro_q[cmd.pos]]};
			end
			LD_ACC_WV:    acc_q <= {{(ACC_W-DATA_WIDTH){wv_q[cmd.pos][DATA_WIDTH-1]}}, wv_q[cmd.pos]};
			LD_ACC_SUB:   acc_q <= acc_q - {{(ACC_W-MQ_W){mq_q[MQ_W-1]}}, mq_q};
			LD_WV_SAT:    wv_q[cmd.pos] <= sat_acc(acc_q);
			LD_WV_DIV:    wv_q[cmd.pos] <= quot;
			LD_WV_ZERO:   wv_q[cmd.pos] <= '0;
			LD_OUT:       out_q <= wv_q[cmd.pos];
			default: begin
			end
		endcase
	end

	assign out_value = out_q;
	assign singular  = sing_q;

endmodule

`default_nettype wire

[hdl/plu_ctrl.sv]
// ----------------------------------------------------------------------------
// plu_ctrl
// Controller: sequences loading, factoring, substitution and result output
// through requests to the datapath.
// ----------------------------------------------------------------------------
`default_nettype none

module plu_ctrl (
	input  wire logic                     clk,
	input  wire logic                     arst_n,
	input  wire logic [plu_pkg::ORD_W-1:0] n,
	input  wire logic                     s_tvalid,
	input  wire logic                     s_tuser,
	input  wire logic                     s_tlast,
	output logic                          s_tready,
	output logic                          m_tvalid,
	output logic                          m_tlast,
	input  wire logic                     m_tready,
	output plu_pkg::dp_cmd_t              cmd,
	input  wire plu_pkg::dp_stat_t        stat
);
	import plu_pkg::*;

	ctl_state_t          state_q, state_d;
	ctl_xstate_t         xs_q, xs_d;
	logic [ORD_W-1:0]    i_q, i_d, j_q, j_d, k_q, k_d;
	logic [CNT_W-1:0]    cnt_q, cnt_d, rem_q, rem_d;
	logic [IDX_W-1:0]    row_q, row_d;
	logic                last_q, last_d;
	logic [NSQ_W-1:0]    nsq;

	assign nsq = n * n;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			xs_q    <= XS_NONE;
			i_q     <= '0;
			j_q     <= '0;
			k_q     <= '0;
			cnt_q   <= '0;
			rem_q   <= '0;
			row_q   <= '0;
			last_q  <= 1'b0;
		end else begin
			state_q <= state_d;
			xs_q    <= xs_d;
			i_q     <= i_d;
			j_q     <= j_d;
			k_q     <= k_d;
			cnt_q   <= cnt_d;
			rem_q   <= rem_d;
			row_q   <= row_d;
			last_q  <= last_d;
		end
	end

	always_comb begin
		state_d  = state_q;
		xs_d     = xs_q;
		i_d      = i_q;
		j_d      = j_q;
		k_d      = k_q;
		cnt_d    = cnt_q;
		rem_d    = rem_q;
		row_d    = row_q;
		last_d   = last_q;
		cmd      = '0;
		s_tready = 1'b0;
		m_tvalid = 1'b0;
		m_tlast  = 1'b0;

		unique case (xs_q)
			XS_BK_DW: begin
				cmd.pos = i_q[IDX_W-1:0];
				if (!stat.div_busy) begin
					cmd.ld = LD_WV_DIV;
					xs_d   = XS_NONE;
					state_d = ST_BK_I;
				end
			end
			XS_EMIT: begin
				cmd.ld  = LD_OUT;
				cmd.pos = i_q[IDX_W-1:0];
				xs_d    = XS_OUT;
			end
			XS_OUT: begin
				m_tvalid = 1'b1;
				m_tlast  = (i_q == n - 1'b1);
				if (m_tready) begin
					if (i_q == n - 1'b1) begin
						xs_d    = XS_NONE;
						state_d = ST_IDLE;
					end else begin
						i_d  = i_q + 1'b1;
						xs_d = XS_EMIT;
					end
				end
			end
			default: begin
				unique case (state_q)
					ST_IDLE: begin
						s_tready = 1'b1;
						if (s_tvalid) begin
							if (!s_tuser) begin
								cmd.cap_in = 1'b1;
								last_d     = s_tlast;
								if (NSQ_W'(cnt_q) < nsq) begin
									rem_d   = cnt_q;
									row_d   = '0;
									state_d = ST_LDIV;
								end else if (s_tlast) begin
									cnt_d   = '0;
									state_d = ST_F_INIT;
								end
							end else begin
								if (cnt_q < CNT_W'(n)) begin
									cmd.ld  = LD_RHS;
									cmd.pos = cnt_q[IDX_W-1:0];
									cnt_d   = cnt_q + 1'b1;
								end
								if (s_tlast) begin
									cnt_d   = '0;
									i_d     = '0;
									state_d = ST_FWD_I;
								end
							end
						end
					end
					// Row and column of the load count by repeated subtraction of n.
					ST_LDIV: begin
						if (rem_q >= CNT_W'(n)) begin
							rem_d = rem_q - CNT_W'(n);
							row_d = row_q + 1'b1;
						end else begin
							cmd.ram_wr = 1'b1;
							cmd.phys   = 1'b1;
							cmd.pos    = row_q;
							cmd.col    = rem_q[IDX_W-1:0];
							cmd.wsel   = WS_IN;
							cnt_d      = cnt_q + 1'b1;
							if (last_q) begin
								cnt_d   = '0;
								state_d = ST_F_INIT;
							end else begin
								state_d = ST_IDLE;
							end
						end
					end
					ST_F_INIT: begin
						cmd.ld  = LD_RO_INIT;
						i_d     = '0;
						state_d = ST_F_COL;
					end
					ST_F_COL: begin
						if (i_q == n) begin
							state_d = ST_IDLE;
						end else begin
							cmd.ram_rd = 1'b1;
							cmd.pos    = i_q[IDX_W-1:0];
							cmd.col    = i_q[IDX_W-1:0];
							state_d    = ST_F_BI;
						end
					end
					ST_F_BI: begin
						cmd.ld  = LD_BEST_INIT;
						cmd.pos = i_q[IDX_W-1:0];
						j_d     = i_q + 1'b1;
						state_d = ST_F_SRCH;
					end
					ST_F_SRCH: begin
						if (j_q == n) begin
							state_d = ST_F_SWAP;
						end else begin
							cmd.ram_rd = 1'b1;
							cmd.pos    = j_q[IDX_W-1:0];
							cmd.col    = i_q[IDX_W-1:0];
							state_d    = ST_F_SCMP;
						end
					end
					ST_F_SCMP: begin
						cmd.ld  = LD_BEST_CMP;
						cmd.pos = j_q[IDX_W-1:0];
						j_d     = j_q + 1'b1;
						state_d = ST_F_SRCH;
					end
					ST_F_SWAP: begin
						cmd.ld  = LD_SWAP;
						cmd.pos = i_q[IDX_W-1:0];
						state_d = ST_F_RP;
					end
					ST_F_RP: begin
						cmd.ram_rd = 1'b1;
						cmd.pos    = i_q[IDX_W-1:0];
						cmd.col    = i_q[IDX_W-1:0];
						state_d    = ST_F_PIV;
					end
					ST_F_PIV: begin
						cmd.ld = LD_PIV;
						if (stat.rd_zero) begin
							i_d     = i_q + 1'b1;
							state_d = ST_F_COL;
						end else begin
							j_d     = i_q + 1'b1;
							state_d = ST_F_ROW;
						end
					end
					ST_F_ROW: begin
						if (j_q == n) begin
							i_d     = i_q + 1'b1;
							state_d = ST_F_COL;
						end else begin
							cmd.ram_rd = 1'b1;
							cmd.pos    = j_q[IDX_W-1:0];
							cmd.col    = i_q[IDX_W-1:0];
							state_d    = ST_F_DIV;
						end
					end
					ST_F_DIV: begin
						cmd.div_start = 1'b1;
						state_d       = ST_F_DWT;
					end
					ST_F_DWT: begin
						if (!stat.div_busy) begin
							cmd.ld  = LD_ALPHA;
							k_d     = i_q + 1'b1;
							state_d = ST_E_K;
						end
					end
					ST_E_K: begin
						if (k_q == n) begin
							cmd.ram_wr = 1'b1;
							cmd.pos    = j_q[IDX_W-1:0];
							cmd.col    = i_q[IDX_W-1:0];
							cmd.wsel   = WS_ALPHA;
							j_d        = j_q + 1'b1;
							state_d    = ST_F_ROW;
						end else begin
							cmd.ram_rd = 1'b1;
							cmd.pos    = i_q[IDX_W-1:0];
							cmd.col    = k_q[IDX_W-1:0];
							state_d    = ST_E_B;
						end
					end
					ST_E_B: begin
						cmd.ld     = LD_B;
						cmd.ram_rd = 1'b1;
						cmd.pos    = j_q[IDX_W-1:0];
						cmd.col    = k_q[IDX_W-1:0];
						state_d    = ST_E_C;
					end
					ST_E_C: begin
						cmd.ld  = LD_C;
						cmd.mul = 1'b1;
						state_d = ST_E_RND;
					end
					ST_E_RND: begin
						cmd.rnd = 1'b1;
						state_d = ST_E_WR;
					end
					ST_E_WR: begin
						cmd.ram_wr = 1'b1;
						cmd.pos    = j_q[IDX_W-1:0];
						cmd.col    = k_q[IDX_W-1:0];
						cmd.wsel   = WS_UPD;
						k_d        = k_q + 1'b1;
						state_d    = ST_E_K;
					end
					ST_FWD_I: begin
						if (i_q == n) begin
							state_d = ST_BK_I;
						end else begin
							cmd.ld  = LD_ACC_RHS;
							cmd.pos = i_q[IDX_W-1:0];
							j_d     = '0;
							state_d = ST_FWD_J;
						end
					end
					ST_FWD_J: begin
						if (j_q == i_q) begin
							cmd.ld  = LD_WV_SAT;
							cmd.pos = i_q[IDX_W-1:0];
							i_d     = i_q + 1'b1;
							state_d = ST_FWD_I;
						end else begin
							cmd.ram_rd = 1'b1;
							cmd.pos    = i_q[IDX_W-1:0];
							cmd.col    = j_q[IDX_W-1:0];
							state_d    = ST_FWD_A;
						end
					end
					ST_FWD_A: begin
						cmd.ld  = LD_A_RD;
						cmd.col = j_q[IDX_W-1:0];
						state_d = ST_FWD_M;
					end
					ST_FWD_M: begin
						cmd.mul = 1'b1;
						state_d = ST_FWD_R;
					end
					ST_FWD_R: begin
						cmd.rnd = 1'b1;
						state_d = ST_FWD_S;
					end
					ST_FWD_S: begin
						cmd.ld  = LD_ACC_SUB;
						j_d     = j_q + 1'b1;
						state_d = ST_FWD_J;
					end
					ST_BK_I: begin
						if (i_q == '0) begin
							xs_d = XS_EMIT;
						end else begin
							i_d     = i_q - 1'b1;
							state_d = ST_BK_A;
						end
					end
					ST_BK_A: begin
						cmd.ld  = LD_ACC_WV;
						cmd.pos = i_q[IDX_W-1:0];
						j_d     = i_q + 1'b1;
						state_d = ST_BK_J;
					end
					ST_BK_J: begin
						cmd.ram_rd = 1'b1;
						cmd.pos    = i_q[IDX_W-1:0];
						if (j_q == n) begin
							cmd.col = i_q[IDX_W-1:0];
							state_d = ST_BK_D;
						end else begin
							cmd.col = j_q[IDX_W-1:0];
							state_d = ST_BK_LA;
						end
					end
					ST_BK_LA: begin
						cmd.ld  = LD_A_RD;
						cmd.col = j_q[IDX_W-1:0];
						state_d = ST_BK_M;
					end
					ST_BK_M: begin
						cmd.mul = 1'b1;
						state_d = ST_BK_R;
					end
					ST_BK_R: begin
						cmd.rnd = 1'b1;
						state_d = ST_BK_S;
					end
					ST_BK_S: begin
						cmd.ld  = LD_ACC_SUB;
						j_d     = j_q + 1'b1;
						state_d = ST_BK_J;
					end
					ST_BK_D: begin
						cmd.pos = i_q[IDX_W-1:0];
						if (stat.rd_zero) begin
							cmd.ld  = LD_WV_ZERO;
							state_d = ST_BK_I;
						end else begin
							cmd.div_start = 1'b1;
							cmd.div_solve = 1'b1;
							xs_d          = XS_BK_DW;
						end
					end
					default: begin
						state_d = ST_IDLE;
					end
				endcase
			end
		endcase

		// The solve divider takes its operands from the request of the start cycle only.
		if (xs_q == XS_BK_DW) begin
			cmd.div_solve = 1'b1;
		end
	end

endmodule

`default_nettype wire

[hdl/pivoted_lu_factor_and_solve.sv]
// ----------------------------------------------------------------------------
// pivoted_lu_factor_and_solve
// LU factoring with partial pivoting and forward/back substitution, Q16.16.
// ----------------------------------------------------------------------------
// Matrix elements (tuser 0) are taken in row-major order; the row and column
// of each are found by subtracting n from the element count repeatedly. The
// element marked last starts the factoring, which runs on one multiplier and
// one bit-serial divider over the single port of the matrix RAM: each element
// update reads, multiplies, rounds and writes back, each pivot search scans the
// column below the diagonal, and each eliminated row first waits for its
// quotient from the divider. Vector elements (tuser 1) are taken one per cycle;
// the one marked last starts the substitution, and then the n solutions leave
// in order, each held until the output is ready.
// No new request is taken until the work of the current one has been handed
// over. The order n is written through the configuration port; the user must
// write it only while idle, which the block itself does not enforce.
// ----------------------------------------------------------------------------
`default_nettype none

module pivoted_lu_factor_and_solve (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        psel,
	input  wire logic        penable,
	input  wire logic        pwrite,
	input  wire logic [2:0]  paddr,
	input  wire logic [31:0] pwdata,
	output logic      [31:0] prdata,
	output logic             pready,
	input  wire logic        s_tvalid,
	output logic             s_tready,
	input  wire logic [31:0] s_tdata,   // [31:0] value
	input  wire logic        s_tuser,   // [0] mode
	input  wire logic        s_tlast,
	output logic             m_tvalid,
	input  wire logic        m_tready,
	output logic [31:0]      m_tdata,   // [31:0] solution
	output logic             m_tuser,   // [0] singular
	output logic             m_tlast
);
	import plu_pkg::*;

	logic [SIZE_W-1:0] size_q;
	logic [ORD_W-1:0]  n;
	dp_cmd_t           cmd;
	dp_stat_t          stat;

	assign pready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			size_q <= SIZE_RESET;
		end else if (psel && penable && pwrite && paddr == REG_SIZE_ADDR) begin
			size_q <= pwdata[SIZE_W-1:0];
		end
	end

	assign prdata = (paddr == REG_SIZE_ADDR) ? {{(32-SIZE_W){1'b0}}, size_q} : '0;

	always_comb begin
		if (size_q == '0) begin
			n = ORD_W'(1);
		end else if (size_q > SIZE_W'(MAX_ORDER)) begin
			n = ORD_W'(MAX_ORDER);
		end else begin
			n = size_q[ORD_W-1:0];
		end
	end

	plu_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.n        (n),
		.s_tvalid (s_tvalid),
		.s_tuser  (s_tuser),
		.s_tlast  (s_tlast),
		.s_tready (s_tready),
		.m_tvalid (m_tvalid),
		.m_tlast  (m_tlast),
		.m_tready (m_tready),
		.cmd      (cmd),
		.stat     (stat)
	);

	plu_dp u_dp (
		.clk       (clk),
		.arst_n    (arst_n),
		.cmd       (cmd),
		.stat      (stat),
		.in_value  (s_tdata),
		.out_value (m_tdata),
		.singular  (m_tuser)
	);

endmodule

`default_nettype wire
